/* src/cartridge_bank_mapper_irq_macros.svh */
// ---------------------------------------------------------------------------
// cartridge bank mapper assertion macros
// shared concurrent assertion forms used by the mapper rtl
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define CBM_ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cbm assertion failed");

// next-cycle implication, disabled while reset is asserted
`define CBM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cbm assertion failed");

`endif

/* src/cbm_pkg.sv */
// ---------------------------------------------------------------------------
// cbm_pkg
// types, codes and helpers shared by the cartridge bank mapper
// ---------------------------------------------------------------------------
package cbm_pkg;

    // item operation codes
    typedef enum logic [2:0] {
        OP_WRITE     = 3'd0,
        OP_READ      = 3'd1,
        OP_TICK      = 3'd2,
        OP_PRG_XLATE = 3'd3,
        OP_CHR_XLATE = 3'd4
    } op_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_VALUE     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_RAM       = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_LAST_BANK = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_LAST_BANK = 8'd3;
    localparam int CFG_DATA_W = 10;

    // configuration reset values
    localparam logic [7:0] DIP_RESET      = 8'hFF;
    localparam logic [9:0] PRG_LAST_RESET = 10'd31;
    localparam logic [9:0] CHR_LAST_RESET = 10'd255;

    // cpu address map
    localparam logic [15:0] ADDR_DIP          = 16'h5000;
    localparam logic [15:0] ADDR_SCRATCH_LO   = 16'h5100;
    localparam logic [15:0] ADDR_SCRATCH_HI   = 16'h5103;
    localparam logic [15:0] ADDR_LOW_AREA_END = 16'h5FFF;
    localparam logic [15:0] ADDR_WRAM_END     = 16'h7FFF;
    localparam logic [15:0] ADDR_OUTER_2K     = 16'h8000;
    localparam logic [15:0] ADDR_OUTER_A      = 16'hB000;
    localparam logic [15:0] ADDR_OUTER_B      = 16'hB0FF;
    localparam logic [15:0] ADDR_OUTER_C      = 16'hB1FF;
    localparam logic [15:0] ADDR_MODE         = 16'h8100;
    localparam logic [15:0] ADDR_IRQ_LO       = 16'h8200;
    localparam logic [15:0] ADDR_IRQ_HI       = 16'h8201;
    localparam logic [15:0] ADDR_PRG_LO       = 16'h8300;
    localparam logic [15:0] ADDR_PRG_HI       = 16'h8302;
    localparam logic [15:0] ADDR_CHR_LO       = 16'h8310;
    localparam logic [15:0] ADDR_CHR_HI       = 16'h8317;
    localparam logic [15:0] ADDR_VETO_LO      = 16'h8312;
    localparam logic [15:0] ADDR_VETO_HI      = 16'h8315;

    // mode register bits and counter reload
    localparam int MODE_PRG16_BIT  = 6;
    localparam int MODE_OPENBUS_BIT = 5;
    localparam int MODE_IRQ_EN_BIT = 7;
    localparam logic [15:0] IRQ_RELOAD = 16'hFFFF;
    localparam logic [7:0]  OUTER_HI_MASK = 8'h30;
    localparam logic [7:0]  OUTER_LO_FILL = 8'h0F;

    // configuration seen by the datapath
    typedef struct packed {
        logic [7:0] dip_value;
        logic       prg_ram_present;
        logic [9:0] prg_last_bank_8k;
        logic [9:0] chr_last_bank_1k;
    } cfg_t;

    // one input item
    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  open_bus_value;
        logic [7:0]  other_read_value;
    } item_t;

    // one result item
    typedef struct packed {
        logic [1:0]  mirroring;
        logic        irq_line;
        logic [22:0] rom_address;
        logic [7:0]  read_data;
    } result_t;

    // bank number above the last bank is masked by it
    function automatic logic [9:0] limit_bank(input logic [9:0] v, input logic [9:0] maxv);
        return (v > maxv) ? (v & maxv) : v;
    endfunction

endpackage

/* src/cartridge_bank_mapper_irq.sv */
// ---------------------------------------------------------------------------
// cartridge_bank_mapper_irq
// Cartridge bank mapper with a cpu cycle irq counter.
//
// The s_ channel carries one item per handshake: a cpu write, cpu read,
// cycle tick, prg translate or chr translate, selected by s_tuser. Every
// item yields exactly one result item on the m_ channel: read byte,
// translated rom address, irq level and mirroring mode.
// Items are registered on entry, decoded and applied to the mapper state as
// they move on, and the result is registered: each item passes the input
// register and then the output register before m_tvalid offers its result.
// One item per clock is sustained while m_tready stays high; the rate is
// set by the single pass through the decode and translate logic in cbm_core.
// When m_tready is low the finished result is held, one more item is taken
// into the input register, and then s_tready drops until the result leaves.
// The cfg channel is always ready; registers 0..3 are dip value, work ram
// present, last 8 KB prg bank and last 1 KB chr bank; other indexes are
// ignored. Write it only while the block is idle.
// Synchronous active-low reset clears all mapper state and restores the
// configuration defaults; no item is lost or invented across a stall.
// ---------------------------------------------------------------------------
`include "cartridge_bank_mapper_irq_macros.svh"

module cartridge_bank_mapper_irq
    import cbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // item input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // address[15:0], write_data[23:16],
                                             // open_bus_value[31:24], other_read_value[39:32]
    input  logic [2:0]            s_tuser,   // operation[2:0]
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,   // read_data[7:0], rom_address[30:8],
                                             // irq_line[31], mirroring[33:32], zero[39:34]
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    stall_full;

    // item moves from input register to output register
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dip_value        <= DIP_RESET;
            cfg_reg.prg_ram_present  <= 1'b0;
            cfg_reg.prg_last_bank_8k <= PRG_LAST_RESET;
            cfg_reg.chr_last_bank_1k <= CHR_LAST_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DIP_VALUE:     cfg_reg.dip_value        <= cfg_data[7:0];
                CFG_PRG_RAM:       cfg_reg.prg_ram_present  <= cfg_data[0];
                CFG_PRG_LAST_BANK: cfg_reg.prg_last_bank_8k <= cfg_data;
                CFG_CHR_LAST_BANK: cfg_reg.chr_last_bank_1k <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.operation        <= s_tuser;
            item_reg.address          <= s_tdata[15:0];
            item_reg.write_data       <= s_tdata[23:16];
            item_reg.open_bus_value   <= s_tdata[31:24];
            item_reg.other_read_value <= s_tdata[39:32];
        end
    end

    // mapper datapath
    cbm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.mirroring, out_reg.irq_line,
                       out_reg.rom_address, out_reg.read_data};

    // both registers hold items and the receiver is stalled
    assign stall_full = in_valid_reg && out_valid_reg && !m_tready;

    // checks on the pipeline control
    `CBM_ASSERT_IMPLIES(a_full_stall_blocks_input, aclk, aresetn, stall_full, !s_tready)
    `CBM_ASSERT_IMPLIES(a_empty_input_ready, aclk, aresetn, !in_valid_reg, s_tready)
    `CBM_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, out_valid_reg)

endmodule

/* src/cbm_core.sv */
// ---------------------------------------------------------------------------
// cbm_core
// mapper state, register write decode, read decode, irq counter and
// prg/chr address translation for one item per enabled cycle
// ---------------------------------------------------------------------------
module cbm_core
    import cbm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    logic [7:0]  prg_bank_reg [3];
    logic [7:0]  prg_bank_next [3];
    logic [7:0]  chr_bank_reg [8];
    logic [7:0]  chr_bank_next [8];
    logic [7:0]  scratch_reg [4];
    logic [7:0]  scratch_next [4];
    logic [7:0]  mode_reg, mode_next;
    logic [7:0]  outer_reg, outer_next;
    logic        two_k_seen_reg, two_k_seen_next;
    logic        two_k_veto_reg, two_k_veto_next;
    logic        irq_en_reg, irq_en_next;
    logic [15:0] irq_cnt_reg, irq_cnt_next;
    logic        irq_pend_reg, irq_pend_next;

    logic [15:0] a;
    logic [7:0]  d;
    logic [15:0] cnt_dec;
    logic [7:0]  rd;
    logic [22:0] rom;
    logic [1:0]  prg_slot;
    logic [2:0]  chr_slot;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_bank_sel;
    logic [9:0]  bank_v;
    logic        two_k_mode;

    assign a       = item.address;
    assign d       = item.write_data;
    assign cnt_dec = irq_cnt_reg - 16'd1;

    // state update: register writes and counter tick
    always_comb begin
        prg_bank_next   = prg_bank_reg;
        chr_bank_next   = chr_bank_reg;
        scratch_next    = scratch_reg;
        mode_next       = mode_reg;
        outer_next      = outer_reg;
        two_k_seen_next = two_k_seen_reg;
        two_k_veto_next = two_k_veto_reg;
        irq_en_next     = irq_en_reg;
        irq_cnt_next    = irq_cnt_reg;
        irq_pend_next   = irq_pend_reg;
        case (item.operation)
            OP_WRITE: begin
                if (a >= ADDR_SCRATCH_LO && a <= ADDR_SCRATCH_HI) begin
                    scratch_next[a[1:0]] = d;
                end else if (a == ADDR_OUTER_2K) begin
                    two_k_seen_next           = 1'b1;
                    outer_next                = d;
                    mode_next[MODE_PRG16_BIT] = 1'b1;
                end else if (a == ADDR_OUTER_A || a == ADDR_OUTER_B || a == ADDR_OUTER_C) begin
                    outer_next                = d;
                    mode_next[MODE_PRG16_BIT] = 1'b1;
                end else if (a == ADDR_MODE) begin
                    mode_next                 = d;
                    mode_next[MODE_PRG16_BIT] = d[MODE_PRG16_BIT] | mode_reg[MODE_PRG16_BIT];
                end else if (a == ADDR_IRQ_LO) begin
                    irq_cnt_next[7:0] = d;
                    irq_pend_next     = 1'b0;
                end else if (a == ADDR_IRQ_HI) begin
                    irq_en_next        = mode_reg[MODE_IRQ_EN_BIT];
                    irq_cnt_next[15:8] = d;
                end else if (a >= ADDR_PRG_LO && a <= ADDR_PRG_HI) begin
                    prg_bank_next[a[1:0]]     = d;
                    mode_next[MODE_PRG16_BIT] = 1'b0;
                end else if (a >= ADDR_CHR_LO && a <= ADDR_CHR_HI) begin
                    chr_bank_next[a[2:0]] = d;
                    if (a >= ADDR_VETO_LO && a <= ADDR_VETO_HI) begin
                        two_k_veto_next = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (irq_en_reg) begin
                    if (cnt_dec == 16'd0) begin
                        irq_pend_next = 1'b1;
                        irq_en_next   = 1'b0;
                        irq_cnt_next  = IRQ_RELOAD;
                    end else begin
                        irq_cnt_next = cnt_dec;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // cpu read decode
    always_comb begin
        if (a == ADDR_DIP) begin
            rd = cfg.dip_value;
        end else if (a >= ADDR_SCRATCH_LO && a <= ADDR_SCRATCH_HI) begin
            rd = scratch_reg[a[1:0]];
        end else if (a <= ADDR_LOW_AREA_END) begin
            rd = item.other_read_value;
        end else if (a <= ADDR_WRAM_END && !cfg.prg_ram_present) begin
            rd = mode_reg[MODE_OPENBUS_BIT] ? item.open_bus_value : a[15:8];
        end else begin
            rd = item.open_bus_value;
        end
    end

    // chr bank select: 2 KB mode picks banks 0, 1, 6, 7
    assign two_k_mode = two_k_seen_reg && !two_k_veto_reg;
    assign prg_slot   = a[14:13];
    assign chr_slot   = a[12:10];
    always_comb begin
        case (chr_slot[2:1])
            2'd0:    chr_idx = 3'd0;
            2'd1:    chr_idx = 3'd1;
            2'd2:    chr_idx = 3'd6;
            default: chr_idx = 3'd7;
        endcase
        if (!two_k_mode) begin
            chr_idx = chr_slot;
        end
    end
    assign chr_bank_sel = chr_bank_reg[chr_idx];

    // prg and chr translation
    always_comb begin
        bank_v = 10'd0;
        rom    = 23'd0;
        case (item.operation)
            OP_PRG_XLATE: begin
                if (mode_reg[MODE_PRG16_BIT]) begin
                    if (!prg_slot[1]) begin
                        bank_v = limit_bank({4'd0, outer_reg[5:0]},
                                            {1'b0, cfg.prg_last_bank_8k[9:1]});
                    end else begin
                        bank_v = limit_bank({2'd0, (outer_reg & OUTER_HI_MASK) | OUTER_LO_FILL},
                                            {1'b0, cfg.prg_last_bank_8k[9:1]});
                    end
                    rom = {bank_v[8:0], a[13:0]};
                end else begin
                    if (prg_slot == 2'd3) begin
                        bank_v = cfg.prg_last_bank_8k;
                    end else begin
                        bank_v = limit_bank({2'd0, prg_bank_reg[prg_slot]},
                                            cfg.prg_last_bank_8k);
                    end
                    rom = {bank_v, a[12:0]};
                end
            end
            OP_CHR_XLATE: begin
                if (two_k_mode) begin
                    bank_v = limit_bank({2'd0, chr_bank_sel},
                                        {1'b0, cfg.chr_last_bank_1k[9:1]});
                    rom = {2'd0, bank_v, chr_slot[0], a[9:0]};
                end else begin
                    bank_v = limit_bank({outer_reg[5:4], chr_bank_sel}, cfg.chr_last_bank_1k);
                    rom = {3'd0, bank_v, a[9:0]};
                end
            end
            default: begin
            end
        endcase
    end

    // result uses the state after this item
    always_comb begin
        result.read_data   = (item.operation == OP_READ) ? rd : 8'd0;
        result.rom_address = rom;
        result.irq_line    = irq_pend_next;
        result.mirroring   = mode_next[1:0];
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) prg_bank_reg[i] <= 8'd0;
            for (int i = 0; i < 8; i++) chr_bank_reg[i] <= 8'd0;
            for (int i = 0; i < 4; i++) scratch_reg[i] <= 8'd0;
            mode_reg       <= 8'd0;
            outer_reg      <= 8'd0;
            two_k_seen_reg <= 1'b0;
            two_k_veto_reg <= 1'b0;
            irq_en_reg     <= 1'b0;
            irq_cnt_reg    <= 16'd0;
            irq_pend_reg   <= 1'b0;
        end else if (en) begin
            prg_bank_reg   <= prg_bank_next;
            chr_bank_reg   <= chr_bank_next;
            scratch_reg    <= scratch_next;
            mode_reg       <= mode_next;
            outer_reg      <= outer_next;
            two_k_seen_reg <= two_k_seen_next;
            two_k_veto_reg <= two_k_veto_next;
            irq_en_reg     <= irq_en_next;
            irq_cnt_reg    <= irq_cnt_next;
            irq_pend_reg   <= irq_pend_next;
        end
    end

endmodule

/* dv/cbm_result_checker.sv */
// ---------------------------------------------------------------------------
// cbm_result_checker
// Watches the item, result and configuration channels of the bank mapper,
// keeps its own copy of the mapper state, predicts one result per accepted
// item and compares every result leaving the block against the oldest
// prediction, field by field.
// ---------------------------------------------------------------------------
module cbm_result_checker
    import cbm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [39:0]           s_tdata,   // address[15:0], write_data[23:16],
                                             // open_bus_value[31:24], other_read_value[39:32]
    input  logic [2:0]            s_tuser,   // operation[2:0]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,   // read_data[7:0], rom_address[30:8],
                                             // irq_line[31], mirroring[33:32]
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    results_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         REPORT_LIMIT     = 10;
    localparam logic [7:0] OUTER_PRG16_MASK = 8'h3F;

    // mirrored mapper state
    logic [7:0]  bank_reg [11];
    logic [7:0]  scratch_reg [4];
    logic [7:0]  mode_q;
    logic [7:0]  outer_q;
    logic        two_k_seen_q;
    logic        two_k_veto_q;
    logic        irq_armed;
    logic        irq_flag;
    logic [15:0] irq_count;

    // mirrored configuration
    logic [7:0]  dip_q;
    logic        wram_fitted;
    logic [9:0]  prg_last;
    logic [9:0]  chr_last;

    result_t expected_bus_results [$];
    int      fail_tally = 0;

    function automatic void clear_mapper_state();
        foreach (bank_reg[i]) bank_reg[i] = '0;
        foreach (scratch_reg[i]) scratch_reg[i] = '0;
        mode_q       = '0;
        outer_q      = '0;
        two_k_seen_q = 1'b0;
        two_k_veto_q = 1'b0;
        irq_armed    = 1'b0;
        irq_flag     = 1'b0;
        irq_count    = '0;
        dip_q        = DIP_RESET;
        wram_fitted  = 1'b0;
        prg_last     = PRG_LAST_RESET;
        chr_last     = CHR_LAST_RESET;
    endfunction

    // bank numbers past the last bank are masked by it
    function automatic int unsigned clamp_bank(int unsigned bank, int unsigned last);
        return (bank > last) ? (bank & last) : bank;
    endfunction

    function automatic logic [22:0] prg_rom_address(logic [15:0] addr);
        int unsigned slot;
        int unsigned bank;
        int unsigned last16;
        slot = addr[14:13];
        // 16 KB mode, upper half pinned to the last bank of the outer group
        if (mode_q[MODE_PRG16_BIT]) begin
            last16 = prg_last >> 1;
            if (slot < 2)
                bank = clamp_bank(outer_q & OUTER_PRG16_MASK, last16);
            else
                bank = clamp_bank((outer_q & OUTER_HI_MASK) | OUTER_LO_FILL, last16);
            return 23'((bank << 14) | addr[13:0]);
        end
        // 8 KB mode, top slot fixed to the last bank
        if (slot == 3)
            bank = prg_last;
        else
            bank = clamp_bank(bank_reg[8 + slot], prg_last);
        return 23'((bank << 13) | addr[12:0]);
    endfunction

    function automatic logic [22:0] chr_rom_address(logic [15:0] addr);
        int unsigned slot;
        int unsigned bank;
        int unsigned pick;
        slot = addr[12:10];
        if (two_k_seen_q && !two_k_veto_q) begin
            case (slot >> 1)
                0: pick = 0;
                1: pick = 1;
                2: pick = 6;
                default: pick = 7;
            endcase
            bank = clamp_bank(bank_reg[pick], chr_last >> 1);
            return 23'((bank << 11) | ((slot & 1) << 10) | addr[9:0]);
        end
        bank = clamp_bank({outer_q[5:4], bank_reg[slot]}, chr_last);
        return 23'((bank << 10) | addr[9:0]);
    endfunction

    function automatic void apply_cpu_write(logic [15:0] a, logic [7:0] d);
        logic [7:0] next_mode;
        if (a >= ADDR_SCRATCH_LO && a <= ADDR_SCRATCH_HI) begin
            scratch_reg[a[1:0]] = d;
        end else if (a == ADDR_OUTER_2K) begin
            two_k_seen_q           = 1'b1;
            outer_q                = d;
            mode_q[MODE_PRG16_BIT] = 1'b1;
        end else if (a == ADDR_OUTER_A || a == ADDR_OUTER_B || a == ADDR_OUTER_C) begin
            outer_q                = d;
            mode_q[MODE_PRG16_BIT] = 1'b1;
        end else if (a == ADDR_MODE) begin
            // prg 16 KB flag can be set but not cleared by mode writes
            next_mode                 = d;
            next_mode[MODE_PRG16_BIT] = d[MODE_PRG16_BIT] | mode_q[MODE_PRG16_BIT];
            mode_q                    = next_mode;
        end else if (a == ADDR_IRQ_LO) begin
            irq_count[7:0] = d;
            irq_flag       = 1'b0;
        end else if (a == ADDR_IRQ_HI) begin
            irq_armed       = mode_q[MODE_IRQ_EN_BIT];
            irq_count[15:8] = d;
        end else if (a >= ADDR_PRG_LO && a <= ADDR_PRG_HI) begin
            bank_reg[8 + a[1:0]]   = d;
            mode_q[MODE_PRG16_BIT] = 1'b0;
        end else if (a >= ADDR_CHR_LO && a <= ADDR_CHR_HI) begin
            bank_reg[a[2:0]] = d;
            if (a >= ADDR_VETO_LO && a <= ADDR_VETO_HI)
                two_k_veto_q = 1'b1;
        end
    endfunction

    function automatic logic [7:0] cpu_read_byte(logic [15:0] a, logic [7:0] open_bus,
                                                 logic [7:0] other);
        if (a == ADDR_DIP)
            return dip_q;
        if (a >= ADDR_SCRATCH_LO && a <= ADDR_SCRATCH_HI)
            return scratch_reg[a[1:0]];
        if (a <= ADDR_LOW_AREA_END)
            return other;
        if (a <= ADDR_WRAM_END && !wram_fitted)
            return mode_q[MODE_OPENBUS_BIT] ? open_bus : a[15:8];
        return open_bus;
    endfunction

    // one item through the mirrored mapper
    function automatic result_t predict_mapper_item(item_t it);
        result_t r;
        r = '0;
        case (it.operation)
            OP_WRITE:     apply_cpu_write(it.address, it.write_data);
            OP_READ:      r.read_data = cpu_read_byte(it.address, it.open_bus_value,
                                                      it.other_read_value);
            OP_TICK: begin
                if (irq_armed) begin
                    irq_count = irq_count - 16'd1;
                    if (irq_count == '0) begin
                        irq_flag  = 1'b1;
                        irq_armed = 1'b0;
                        irq_count = IRQ_RELOAD;
                    end
                end
            end
            OP_PRG_XLATE: r.rom_address = prg_rom_address(it.address);
            OP_CHR_XLATE: r.rom_address = chr_rom_address(it.address);
            default: ;
        endcase
        r.irq_line  = irq_flag;
        r.mirroring = mode_q[1:0];
        return r;
    endfunction

    // sample all channels at the clock edge
    always @(posedge aclk) begin
        item_t   it;
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_mapper_state();
            expected_bus_results.delete();
        end else begin
            // configuration writes
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_DIP_VALUE)
                    dip_q = cfg_data[7:0];
                else if (cfg_index == CFG_PRG_RAM)
                    wram_fitted = cfg_data[0];
                else if (cfg_index == CFG_PRG_LAST_BANK)
                    prg_last = cfg_data;
                else if (cfg_index == CFG_CHR_LAST_BANK)
                    chr_last = cfg_data;
            end
            // result leaving the block
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[33:0]);
                if (expected_bus_results.size() == 0) begin
                    fail_tally++;
                    if (fail_tally <= REPORT_LIMIT)
                        $display("unexpected result item: rd=%h rom=%h irq=%b mir=%h",
                                 got.read_data, got.rom_address, got.irq_line,
                                 got.mirroring);
                end else begin
                    want = expected_bus_results.pop_front();
                    if (got.read_data !== want.read_data ||
                        got.rom_address !== want.rom_address ||
                        got.irq_line !== want.irq_line ||
                        got.mirroring !== want.mirroring) begin
                        fail_tally++;
                        if (fail_tally <= REPORT_LIMIT)
                            $display({"result mismatch: expected rd=%h rom=%h irq=%b mir=%h",
                                      ", got rd=%h rom=%h irq=%b mir=%h"},
                                     want.read_data, want.rom_address, want.irq_line,
                                     want.mirroring, got.read_data, got.rom_address,
                                     got.irq_line, got.mirroring);
                    end
                end
            end
            // item entering the block
            if (s_tvalid && s_tready) begin
                it.operation        = s_tuser;
                it.address          = s_tdata[15:0];
                it.write_data       = s_tdata[23:16];
                it.open_bus_value   = s_tdata[31:24];
                it.other_read_value = s_tdata[39:32];
                expected_bus_results.push_back(predict_mapper_item(it));
            end
        end
        mismatch_count      <= fail_tally;
        results_outstanding <= expected_bus_results.size();
    end

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the cartridge bank mapper: a directed opening,
// then random cpu traffic and irq programming sequences over several
// configuration settings and idle patterns, checked by cbm_result_checker.
// ---------------------------------------------------------------------------
module tb;
    import cbm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]           OP_RESERVED_LO   = 3'd5;
    localparam logic [2:0]           OP_RESERVED_HI   = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED   = 8'd200;
    localparam int                   PHASE_COUNT      = 5;
    localparam int                   ITEMS_PER_PHASE  = 100;
    localparam int                   LONG_HOLD_CYCLES = 60;
    localparam int                   DRAIN_LIMIT      = 5000;
    localparam int                   SETTLE_CYCLES    = 4;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [39:0]           s_tdata   = '0;
    logic [2:0]            s_tuser   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [39:0]           m_tdata;
    wire                   cfg_ready;
    int                    mismatch_count;
    int                    results_outstanding;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    int items_sent   = 0;
    bit drain_timed_out = 1'b0;

    cartridge_bank_mapper_irq dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cbm_result_checker checker_i (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // 12 ns clock
    initial begin
        forever #6 aclk = ~aclk;
    end

    // hard stop
    initial begin
        #(12 * 300000);
        $display("TB_ERROR");
        $finish;
    end

    // result side: long hold-off when requested, random stalls otherwise
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    function automatic item_t make_item(logic [2:0] op, logic [15:0] addr, logic [7:0] wd);
        item_t it;
        it.operation        = op;
        it.address          = addr;
        it.write_data       = wd;
        it.open_bus_value   = 8'($urandom);
        it.other_read_value = 8'($urandom);
        return it;
    endfunction

    // weighted toward decoded addresses so the bank state gets exercised
    function automatic item_t random_item();
        int          pick;
        logic [15:0] addr;
        pick = $urandom_range(99);
        if (pick < 30) begin
            case ($urandom_range(10))
                0: addr = ADDR_SCRATCH_LO + 16'($urandom_range(3));
                1: addr = ADDR_OUTER_2K;
                2: addr = ADDR_OUTER_A;
                3: addr = ADDR_OUTER_B;
                4: addr = ADDR_OUTER_C;
                5: addr = ADDR_MODE;
                6: addr = ADDR_IRQ_LO;
                7: addr = ADDR_PRG_LO + 16'($urandom_range(2));
                8, 9: addr = ADDR_CHR_LO + 16'($urandom_range(7));
                default: addr = 16'($urandom);
            endcase
            return make_item(OP_WRITE, addr, 8'($urandom));
        end
        if (pick < 48) begin
            case ($urandom_range(4))
                0: addr = ADDR_DIP;
                1: addr = ADDR_SCRATCH_LO + 16'($urandom_range(3));
                2: addr = 16'($urandom_range(ADDR_LOW_AREA_END));
                3: addr = 16'($urandom_range(ADDR_WRAM_END, ADDR_LOW_AREA_END + 1));
                default: addr = 16'($urandom);
            endcase
            return make_item(OP_READ, addr, 8'($urandom));
        end
        if (pick < 58)
            return make_item(OP_TICK, 16'($urandom), 8'($urandom));
        if (pick < 77)
            return make_item(OP_PRG_XLATE, 16'($urandom), 8'($urandom));
        if (pick < 95) begin
            addr = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(8191));
            return make_item(OP_CHR_XLATE, addr, 8'($urandom));
        end
        // noise, reserved operations included
        return make_item(3'($urandom_range(7)), 16'($urandom), 8'($urandom));
    endfunction

    // offer one item, wait for its handshake
    task automatic send_item(item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.other_read_value, it.open_bus_value, it.write_data, it.address};
        s_tuser  <= it.operation;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // arm the counter with a count that is mostly short, then send up to 20 ticks
    task automatic irq_sequence();
        int ticks;
        send_item(make_item(OP_WRITE, ADDR_MODE, {1'b1, 7'($urandom)}));
        send_item(make_item(OP_WRITE, ADDR_IRQ_LO, 8'($urandom_range(12))));
        send_item(make_item(OP_WRITE, ADDR_IRQ_HI,
                            ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00));
        ticks = $urandom_range(20);
        repeat (ticks) send_item(make_item(OP_TICK, 16'($urandom), 8'($urandom)));
    endtask

    // wait until every predicted result has come out
    task automatic wait_idle();
        int guard;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        guard = 0;
        while (results_outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (results_outstanding != 0)
            drain_timed_out = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic directed_items();
        // dip, scratch, low area, work ram area without ram, open bus
        send_item(make_item(OP_READ, ADDR_DIP, 8'h00));
        send_item(make_item(OP_WRITE, ADDR_SCRATCH_HI, 8'hA5));
        send_item(make_item(OP_READ, ADDR_SCRATCH_HI, 8'h00));
        send_item(make_item(OP_READ, 16'h0000, 8'h00));
        send_item(make_item(OP_READ, 16'h6000, 8'h00));
        send_item(make_item(OP_READ, 16'hFFFF, 8'h00));
        // 8 KB prg bank past the last bank, translate below 0x8000, fixed top slot
        send_item(make_item(OP_WRITE, ADDR_PRG_LO, 8'hFF));
        send_item(make_item(OP_PRG_XLATE, 16'h8000, 8'h00));
        send_item(make_item(OP_PRG_XLATE, 16'h2000, 8'h00));
        send_item(make_item(OP_PRG_XLATE, 16'hE123, 8'h00));
        // 1 KB chr, pattern address above 8191
        send_item(make_item(OP_WRITE, ADDR_CHR_LO, 8'hFF));
        send_item(make_item(OP_CHR_XLATE, 16'hFFFF, 8'h00));
        // outer bank with 2 KB chr, then veto it
        send_item(make_item(OP_WRITE, ADDR_OUTER_2K, 8'h3F));
        send_item(make_item(OP_PRG_XLATE, 16'hC000, 8'h00));
        send_item(make_item(OP_CHR_XLATE, 16'h1C00, 8'h00));
        send_item(make_item(OP_WRITE, ADDR_VETO_LO, 8'h12));
        send_item(make_item(OP_CHR_XLATE, 16'h0800, 8'h00));
        // irq enable, open bus pattern, single screen 1
        send_item(make_item(OP_WRITE, ADDR_MODE, 8'hA3));
        send_item(make_item(OP_READ, 16'h7ABC, 8'h00));
        // count of two fires on the second tick
        send_item(make_item(OP_WRITE, ADDR_IRQ_LO, 8'h02));
        send_item(make_item(OP_WRITE, ADDR_IRQ_HI, 8'h00));
        repeat (2) send_item(make_item(OP_TICK, 16'h0000, 8'h00));
        // armed from zero wraps and keeps counting
        send_item(make_item(OP_WRITE, ADDR_IRQ_LO, 8'h00));
        send_item(make_item(OP_WRITE, ADDR_IRQ_HI, 8'h00));
        send_item(make_item(OP_TICK, 16'h0000, 8'h00));
        // undecoded write and reserved operations
        send_item(make_item(OP_WRITE, 16'h8318, 8'h77));
        send_item(make_item(OP_RESERVED_LO, ADDR_DIP, 8'h00));
        send_item(make_item(OP_RESERVED_HI, 16'h8000, 8'h00));
    endtask

    initial begin
        int phase_target;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // configuration while idle: low extremes, high extremes, random
            if (phase == 1) begin
                write_cfg(CFG_DIP_VALUE, 10'h000);
                write_cfg(CFG_PRG_RAM, 10'h001);
                write_cfg(CFG_PRG_LAST_BANK, 10'd1);
                write_cfg(CFG_CHR_LAST_BANK, 10'd1);
                write_cfg(CFG_IDX_UNUSED, 10'($urandom));
            end else if (phase == 2) begin
                write_cfg(CFG_DIP_VALUE, 10'h3FF);
                write_cfg(CFG_PRG_RAM, 10'h000);
                write_cfg(CFG_PRG_LAST_BANK, 10'd1023);
                write_cfg(CFG_CHR_LAST_BANK, 10'd1023);
            end else if (phase > 2) begin
                write_cfg(CFG_DIP_VALUE, 10'($urandom));
                write_cfg(CFG_PRG_RAM, 10'($urandom_range(1)));
                write_cfg(CFG_PRG_LAST_BANK,
                          10'($urandom_range(phase == 3 ? 1023 : 63, 1)));
                write_cfg(CFG_CHR_LAST_BANK,
                          10'($urandom_range(phase == 3 ? 1023 : 63, 1)));
            end
            // idle pattern for this phase
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 47; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 47; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            if (phase == 0)
                directed_items();
            // receiver holds off while items keep coming
            if (phase == 2)
                rx_hold_left = LONG_HOLD_CYCLES;
            phase_target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_target) begin
                if ($urandom_range(99) < 8)
                    irq_sequence();
                else
                    send_item(random_item());
            end
            wait_idle();
        end
        if (mismatch_count == 0 && !drain_timed_out)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* cartridge_bank_mapper_irq.f */
+incdir+src
src/cbm_pkg.sv
src/cbm_core.sv
src/cartridge_bank_mapper_irq.sv
dv/cbm_result_checker.sv
dv/tb.sv
